[hw/rtl/pose_frame_transform_unit_defines.svh]
// Assertion macros for the pose frame transform unit.
// Included by every RTL file that carries concurrent assertions.
// Each macro expects clk and arst_n to be visible in the including scope.
`ifndef POSE_FRAME_TRANSFORM_UNIT_DEFINES_SVH
`define POSE_FRAME_TRANSFORM_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define PFTU_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pose frame transform: assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define PFTU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pose frame transform: assertion failed");
`else
`define PFTU_ASSERT_IMPL(label, ante, cons)
`define PFTU_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[hw/rtl/pftu_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the pose frame transform unit.
// No dependencies; used by the channel interfaces, the trig sequencer and the top level.
package pftu_pkg;

	// Fixed field widths.
	localparam int COORD_W     = 32;
	localparam int OP_W        = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int CFG_INDEX_W = 2;

	// Operation codes of an input beat.
	typedef enum logic [OP_W-1:0] {
		OP_PT_G2L   = 3'd0,
		OP_PT_L2G   = 3'd1,
		OP_POSE_G2L = 3'd2,
		OP_HD_G2L   = 3'd3,
		OP_HD_L2G   = 3'd4
	} op_t;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_BASE_X     = 2'd0,
		REG_BASE_Y     = 2'd1,
		REG_BASE_ANGLE = 2'd2
	} cfg_reg_t;

	// Q30 fixed-point constants of the sine/cosine series.
	localparam logic [31:0] Q30_ONE     = 32'h4000_0000;
	localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

	// Horner series: six terms for sine, then six for cosine.
	localparam int NUM_TERMS = 6;
	localparam int NUM_DIVS  = 2 * NUM_TERMS;

	// Divisor of each Horner step.
	localparam logic [7:0] DIV_D [NUM_DIVS] = '{
		8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6,
		8'd182, 8'd132, 8'd90, 8'd56, 8'd30, 8'd12
	};

	// Reciprocal of each divisor: floor(2^k / d) with k = 32 + floor(log2(d)).
	localparam logic [31:0] DIV_M [NUM_DIVS] = '{
		32'd3524075730, 32'd2498890063, 32'd3817748707,
		32'd3272356035, 32'd3435973836, 32'd2863311530,
		32'd3020636340, 32'd4164816771, 32'd3054198966,
		32'd2454267026, 32'd2290649224, 32'd2863311530
	};

	// Shift k that goes with each reciprocal.
	localparam logic [5:0] DIV_K [NUM_DIVS] = '{
		6'd39, 6'd38, 6'd38, 6'd37, 6'd36, 6'd34,
		6'd39, 6'd39, 6'd38, 6'd37, 6'd36, 6'd35
	};

endpackage

[hw/rtl/pftu_in_if.sv]
`timescale 1ns / 1ps
// Input channel of the pose frame transform unit: valid/ready plus one request beat.
// Depends on pftu_pkg for the fixed field widths.
interface pftu_in_if
	import pftu_pkg::*;
#(
	parameter int ANGLE_BITS = 16
) ();

	logic                         valid;
	logic                         ready;
	logic        [OP_W-1:0]       op;
	logic signed [COORD_W-1:0]    in_x;
	logic signed [COORD_W-1:0]    in_y;
	logic signed [ANGLE_BITS-1:0] in_angle;

	modport source (output valid, output op, output in_x, output in_y, output in_angle,
		input ready);
	modport sink (input valid, input op, input in_x, input in_y, input in_angle,
		output ready);

endinterface

[hw/rtl/pftu_out_if.sv]
`timescale 1ns / 1ps
// Output channel of the pose frame transform unit: valid/ready plus one result beat.
// Depends on pftu_pkg for the fixed field widths.
interface pftu_out_if
	import pftu_pkg::*;
#(
	parameter int ANGLE_BITS = 16
) ();

	logic                         valid;
	logic                         ready;
	logic signed [COORD_W-1:0]    out_x;
	logic signed [COORD_W-1:0]    out_y;
	logic signed [ANGLE_BITS-1:0] out_angle;
	logic                         saturated;

	modport source (output valid, output out_x, output out_y, output out_angle,
		output saturated, input ready);
	modport sink (input valid, input out_x, input out_y, input out_angle,
		input saturated, output ready);

endinterface

[hw/rtl/pose_frame_transform_unit.sv]
`timescale 1ns / 1ps
// Throughput: one beat per cycle through a four-stage pipeline with per-stage valid bits,
// while rsp.ready is high and the sine/cosine sequencer is done.
// After reset and after every base_angle write, the sine/cosine sequencer runs
// on its shared multiplier; req.ready stays low until it is done.
// Reset clears the base pose registers to zero and empties the pipeline.
`include "pose_frame_transform_unit_defines.svh"
module pose_frame_transform_unit
	import pftu_pkg::*;
#(
	parameter int ANGLE_BITS     = 16,
	parameter int TRIG_FRAC_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	pftu_in_if.sink                req,
	pftu_out_if.source             rsp
);

	localparam int TW = TRIG_FRAC_BITS + 2;
	localparam int AW = COORD_W + 1;
	localparam int PW = AW + TW;
	localparam int SW = PW + 1;
	localparam int HW = SW - TRIG_FRAC_BITS;
	localparam int RW = HW + 1;
	localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
	localparam logic signed [SW-1:0]  ROT_RND = SW'(1) << (TRIG_FRAC_BITS - 1);
	localparam logic signed [COORD_W-1:0] C_MAX = signed'(32'h7FFF_FFFF);
	localparam logic signed [COORD_W-1:0] C_MIN = signed'(32'h8000_0000);
	localparam logic signed [RW-1:0] SAT_MAX = RW'(C_MAX);
	localparam logic signed [RW-1:0] SAT_MIN = RW'(C_MIN);

	// Base pose registers.
	logic signed [COORD_W-1:0]    base_x_q;
	logic signed [COORD_W-1:0]    base_y_q;
	logic        [ANGLE_BITS-1:0] base_angle_q;
	logic                         trig_start;
	logic                         trig_ready;
	logic signed [TW-1:0]         sin_val;
	logic signed [TW-1:0]         cos_val;

	// Stage handshake.
	logic en1, en2, en3, en4;
	logic v_s1, v_s2, v_s3, v_s4;

	// Decode of the incoming beat.
	logic                         xy_d, l2g_d;
	logic        [ANGLE_BITS-1:0] ang_d;
	logic signed [AW-1:0]         ix_e, iy_e, dx_d, dy_d;

	// Stage 1: operands.
	logic                         xy_s1, l2g_s1;
	logic        [ANGLE_BITS-1:0] ang_s1;
	logic signed [AW-1:0]         a_s1, b_s1;
	logic signed [COORD_W-1:0]    off_x_s1, off_y_s1;

	// Stage 2: products.
	logic                         xy_s2, l2g_s2;
	logic        [ANGLE_BITS-1:0] ang_s2;
	logic signed [PW-1:0]         p_sa_s2, p_ca_s2, p_sb_s2, p_cb_s2;
	logic signed [COORD_W-1:0]    off_x_s2, off_y_s2;

	// Stage 3: rotated sums with the rounding bias.
	logic                         xy_s3;
	logic        [ANGLE_BITS-1:0] ang_s3;
	logic signed [SW-1:0]         sum_x_s3, sum_y_s3;
	logic signed [COORD_W-1:0]    off_x_s3, off_y_s3;

	// Stage 4: output register.
	logic                         xy_s4;
	logic signed [COORD_W-1:0]    out_x_s4, out_y_s4;
	logic        [ANGLE_BITS-1:0] ang_s4;
	logic                         sat_s4;

	// Final rounding, offset and saturation.
	logic signed [SW-1:0] sa_ext, ca_ext, sb_ext, cb_ext;
	logic signed [RW-1:0] rx, ry;
	logic signed [COORD_W-1:0] cx, cy;
	logic sat_x, sat_y;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_x_q     <= '0;
			base_y_q     <= '0;
			base_angle_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_BASE_X:     base_x_q     <= signed'(cfg_data[COORD_W-1:0]);
				REG_BASE_Y:     base_y_q     <= signed'(cfg_data[COORD_W-1:0]);
				REG_BASE_ANGLE: base_angle_q <= cfg_data[ANGLE_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	assign trig_start = cfg_we && (cfg_reg_t'(cfg_index) == REG_BASE_ANGLE);

	pftu_trig #(
		.ANGLE_BITS     (ANGLE_BITS),
		.TRIG_FRAC_BITS (TRIG_FRAC_BITS)
	) u_trig (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (trig_start),
		.angle   (base_angle_q),
		.ready   (trig_ready),
		.sin_val (sin_val),
		.cos_val (cos_val)
	);

	// A stage moves when it is empty or the stage after it moves.
	assign en4       = !v_s4 || rsp.ready;
	assign en3       = !v_s3 || en4;
	assign en2       = !v_s2 || en3;
	assign en1       = !v_s1 || en2;
	assign req.ready = en1 && trig_ready;

	// Operation decode and heading arithmetic.
	assign ix_e = AW'(req.in_x);
	assign iy_e = AW'(req.in_y);
	assign dx_d = ix_e - AW'(base_x_q);
	assign dy_d = iy_e - AW'(base_y_q);

	always_comb begin
		xy_d  = 1'b0;
		l2g_d = 1'b0;
		ang_d = '0;
		unique case (op_t'(req.op))
			OP_PT_G2L: xy_d = 1'b1;
			OP_PT_L2G: begin
				xy_d  = 1'b1;
				l2g_d = 1'b1;
			end
			OP_POSE_G2L: begin
				xy_d  = 1'b1;
				ang_d = QUARTER + req.in_angle - base_angle_q;
			end
			OP_HD_G2L: ang_d = QUARTER + req.in_angle - base_angle_q;
			OP_HD_L2G: ang_d = req.in_angle + base_angle_q - QUARTER;
			default: begin
				xy_d  = 1'b0;
				l2g_d = 1'b0;
				ang_d = '0;
			end
		endcase
	end

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= req.valid && req.ready;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// Stage 1: pick rotation operands and the base offset.
	always_ff @(posedge clk) begin
		if (en1) begin
			xy_s1    <= xy_d;
			l2g_s1   <= l2g_d;
			ang_s1   <= ang_d;
			a_s1     <= l2g_d ? ix_e : dx_d;
			b_s1     <= l2g_d ? iy_e : dy_d;
			off_x_s1 <= l2g_d ? base_x_q : '0;
			off_y_s1 <= l2g_d ? base_y_q : '0;
		end
	end

	// Stage 2: the four rotation products.
	always_ff @(posedge clk) begin
		if (en2) begin
			xy_s2    <= xy_s1;
			l2g_s2   <= l2g_s1;
			ang_s2   <= ang_s1;
			p_sa_s2  <= PW'(a_s1) * PW'(sin_val);
			p_ca_s2  <= PW'(a_s1) * PW'(cos_val);
			p_sb_s2  <= PW'(b_s1) * PW'(sin_val);
			p_cb_s2  <= PW'(b_s1) * PW'(cos_val);
			off_x_s2 <= off_x_s1;
			off_y_s2 <= off_y_s1;
		end
	end

	// Stage 3: combine products by direction and add the rounding bias.
	assign sa_ext = SW'(p_sa_s2);
	assign ca_ext = SW'(p_ca_s2);
	assign sb_ext = SW'(p_sb_s2);
	assign cb_ext = SW'(p_cb_s2);

	always_ff @(posedge clk) begin
		if (en3) begin
			xy_s3    <= xy_s2;
			ang_s3   <= ang_s2;
			off_x_s3 <= off_x_s2;
			off_y_s3 <= off_y_s2;
			if (l2g_s2) begin
				sum_x_s3 <= sa_ext + cb_ext + ROT_RND;
				sum_y_s3 <= sb_ext - ca_ext + ROT_RND;
			end else begin
				sum_x_s3 <= sa_ext - cb_ext + ROT_RND;
				sum_y_s3 <= ca_ext + sb_ext + ROT_RND;
			end
		end
	end

	// Stage 4: floor shift, base offset and clip to 32 bits.
	assign rx = RW'(signed'(sum_x_s3[SW-1:TRIG_FRAC_BITS])) + RW'(off_x_s3);
	assign ry = RW'(signed'(sum_y_s3[SW-1:TRIG_FRAC_BITS])) + RW'(off_y_s3);

	always_comb begin
		sat_x = 1'b1;
		sat_y = 1'b1;
		if (rx > SAT_MAX) begin
			cx = C_MAX;
		end else if (rx < SAT_MIN) begin
			cx = C_MIN;
		end else begin
			cx    = rx[COORD_W-1:0];
			sat_x = 1'b0;
		end
		if (ry > SAT_MAX) begin
			cy = C_MAX;
		end else if (ry < SAT_MIN) begin
			cy = C_MIN;
		end else begin
			cy    = ry[COORD_W-1:0];
			sat_y = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			xy_s4    <= xy_s3;
			ang_s4   <= ang_s3;
			out_x_s4 <= xy_s3 ? cx : '0;
			out_y_s4 <= xy_s3 ? cy : '0;
			sat_s4   <= xy_s3 && (sat_x || sat_y);
		end
	end

	assign rsp.valid     = v_s4;
	assign rsp.out_x     = out_x_s4;
	assign rsp.out_y     = out_y_s4;
	assign rsp.out_angle = ang_s4;
	assign rsp.saturated = sat_s4;

	// An accepted beat always lands in the first stage.
	`PFTU_ASSERT_NEXT(a_accept_loads_s1, req.valid && req.ready, v_s1)
	// A blocked sum stage keeps its beat intact.
	`PFTU_ASSERT_NEXT(a_s3_holds, v_s3 && !en4,
		v_s3 && $stable(sum_x_s3) && $stable(sum_y_s3))
	// Heading-only beats carry zero coordinates and no clip flag.
	`PFTU_ASSERT_IMPL(a_heading_zero, v_s4 && !xy_s4,
		(out_x_s4 == '0) && (out_y_s4 == '0) && !sat_s4)
	// The clip flag only comes with a coordinate at a rail.
	`PFTU_ASSERT_IMPL(a_sat_rail, v_s4 && sat_s4,
		(out_x_s4 == C_MAX) || (out_x_s4 == C_MIN) || (out_y_s4 == C_MAX) || (out_y_s4 == C_MIN))

endmodule

[hw/rtl/pftu_trig.sv]
`timescale 1ns / 1ps
// Sine/cosine sequencer: evaluates the base heading's sine and cosine with one
// shared 32x32 multiplier. Depends on pftu_pkg and the assertion macro header.
`include "pose_frame_transform_unit_defines.svh"
module pftu_trig
	import pftu_pkg::*;
#(
	parameter int ANGLE_BITS     = 16,
	parameter int TRIG_FRAC_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [ANGLE_BITS-1:0]          angle,
	output logic                           ready,
	output logic signed [TRIG_FRAC_BITS+1:0] sin_val,
	output logic signed [TRIG_FRAC_BITS+1:0] cos_val
);

	localparam int QB = ANGLE_BITS - 2;
	localparam int TW = TRIG_FRAC_BITS + 2;
	localparam int SH = 30 - TRIG_FRAC_BITS;
	localparam logic [31:0] TRIG_RND = 32'(1) << (SH - 1);
	localparam logic [2:0]  LAST_TERM = 3'(NUM_TERMS - 1);
	localparam logic [3:0]  COS_BASE  = 4'(NUM_TERMS);

	localparam logic [1:0] QUAD_I   = 2'd0;
	localparam logic [1:0] QUAD_II  = 2'd1;
	localparam logic [1:0] QUAD_III = 2'd2;
	localparam logic [1:0] QUAD_IV  = 2'd3;

	typedef enum logic [10:0] {
		T_IDLE = 11'b000_0000_0001,
		T_X    = 11'b000_0000_0010,
		T_X2   = 11'b000_0000_0100,
		T_HMUL = 11'b000_0000_1000,
		T_DMUL = 11'b000_0001_0000,
		T_DFIX = 11'b000_0010_0000,
		T_DCOR = 11'b000_0100_0000,
		T_SFIN = 11'b000_1000_0000,
		T_SRND = 11'b001_0000_0000,
		T_CFIN = 11'b010_0000_0000,
		T_CRND = 11'b100_0000_0000
	} trig_state_t;

	trig_state_t state_q;
	logic [2:0]  term_q;
	logic        cos_phase_q;
	logic [1:0]  quad_q;
	logic [31:0] x_q;
	logic [31:0] x2_q;
	logic [31:0] t_q;
	logic [31:0] v_q;
	logic [31:0] qe_q;
	logic [31:0] pd_q;
	logic [TW-2:0] mag_s_q;
	logic signed [TW-1:0] sin_q;
	logic signed [TW-1:0] cos_q;

	logic [3:0]  tab_idx;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] prod;
	logic [31:0] rem;
	logic        rem_ge;
	logic [31:0] rnd_s;
	logic [31:0] cv;
	logic [31:0] rnd_c;
	logic signed [TW-1:0] s_pos;
	logic signed [TW-1:0] c_pos;

	// Table row of the current Horner step.
	assign tab_idx = 4'(term_q) + (cos_phase_q ? COS_BASE : 4'd0);

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			T_X: begin
				mul_a = 32'(angle[QB-1:0]);
				mul_b = HALF_PI_Q30;
			end
			T_X2: begin
				mul_a = x_q;
				mul_b = x_q;
			end
			T_HMUL, T_CFIN: begin
				mul_a = x2_q;
				mul_b = t_q;
			end
			T_DMUL: begin
				mul_a = v_q;
				mul_b = DIV_M[tab_idx];
			end
			T_DFIX: begin
				mul_a = qe_q;
				mul_b = 32'(DIV_D[tab_idx]);
			end
			T_SFIN: begin
				mul_a = x_q;
				mul_b = t_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = 64'(mul_a) * 64'(mul_b);

	// The reciprocal estimate is at most one low; the remainder fixes it.
	assign rem    = v_q - pd_q;
	assign rem_ge = rem >= 32'(DIV_D[tab_idx]);

	// Rounding of the sine and cosine magnitudes, half up.
	assign rnd_s = (v_q + TRIG_RND) >> SH;
	assign cv    = (v_q > Q30_ONE) ? 32'd0 : Q30_ONE - v_q;
	assign rnd_c = (cv + TRIG_RND) >> SH;
	assign s_pos = signed'({1'b0, mag_s_q});
	assign c_pos = signed'({1'b0, rnd_c[TW-2:0]});

	// Sequencer state and control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_X;
			term_q      <= '0;
			cos_phase_q <= 1'b0;
		end else if (start) begin
			state_q     <= T_X;
			term_q      <= '0;
			cos_phase_q <= 1'b0;
		end else begin
			unique case (state_q)
				T_IDLE: state_q <= T_IDLE;
				T_X:    state_q <= T_X2;
				T_X2: begin
					state_q     <= T_HMUL;
					term_q      <= '0;
					cos_phase_q <= 1'b0;
				end
				T_HMUL: state_q <= T_DMUL;
				T_DMUL: state_q <= T_DFIX;
				T_DFIX: state_q <= T_DCOR;
				T_DCOR: begin
					if (term_q == LAST_TERM) begin
						state_q <= cos_phase_q ? T_CFIN : T_SFIN;
					end else begin
						term_q  <= term_q + 3'd1;
						state_q <= T_HMUL;
					end
				end
				T_SFIN: state_q <= T_SRND;
				T_SRND: begin
					state_q     <= T_HMUL;
					term_q      <= '0;
					cos_phase_q <= 1'b1;
				end
				T_CFIN: state_q <= T_CRND;
				T_CRND: state_q <= T_IDLE;
				default: state_q <= T_IDLE;
			endcase
		end
	end

	// Datapath registers of the series evaluation.
	always_ff @(posedge clk) begin
		unique case (state_q)
			T_X: begin
				x_q    <= 32'(prod >> QB);
				quad_q <= angle[ANGLE_BITS-1 -: 2];
			end
			T_X2: begin
				x2_q <= 32'(prod >> 30);
				t_q  <= Q30_ONE;
			end
			T_HMUL: v_q  <= 32'(prod >> 30);
			T_DMUL: qe_q <= 32'(prod >> DIV_K[tab_idx]);
			T_DFIX: pd_q <= prod[31:0];
			T_DCOR: t_q  <= Q30_ONE - qe_q - 32'(rem_ge);
			T_SFIN: v_q  <= 32'(prod >> 30);
			T_SRND: begin
				mag_s_q <= rnd_s[TW-2:0];
				t_q     <= Q30_ONE;
			end
			// Halving the last product is folded into the shift.
			T_CFIN: v_q <= 32'(prod >> 31);
			T_CRND: begin
				unique case (quad_q)
					QUAD_I: begin
						sin_q <= s_pos;
						cos_q <= c_pos;
					end
					QUAD_II: begin
						sin_q <= c_pos;
						cos_q <= -s_pos;
					end
					QUAD_III: begin
						sin_q <= -s_pos;
						cos_q <= -c_pos;
					end
					QUAD_IV: begin
						sin_q <= -c_pos;
						cos_q <= s_pos;
					end
					default: begin
						sin_q <= s_pos;
						cos_q <= c_pos;
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	assign ready   = (state_q == T_IDLE);
	assign sin_val = sin_q;
	assign cos_val = cos_q;

	// A new base heading always forces a fresh evaluation.
	`PFTU_ASSERT_NEXT(a_start_busy, start, !ready)
	// Once finished, the sequencer stays finished until restarted.
	`PFTU_ASSERT_NEXT(a_idle_holds, ready && !start, ready)
	// The published sine and cosine do not move while the pipeline may use them.
	`PFTU_ASSERT_NEXT(a_trig_stable, ready && !start, $stable(sin_q) && $stable(cos_q))

endmodule

[tb/sv/tb_pose_frame_transform_unit.sv]
`timescale 1ns / 1ps
// Self-checking testbench of pose_frame_transform_unit: a directed table, then random beats.
// Depends on pftu_pkg and on the pftu_in_if / pftu_out_if channel interfaces.
module tb_pose_frame_transform_unit;
	import pftu_pkg::*;

	localparam int ANGLE_BITS     = 16;
	localparam int TRIG_FRAC_BITS = 16;

	localparam int          DIRECTED_ROWS    = 24;
	localparam int          RANDOM_PHASES    = 8;
	localparam int          RANDOM_PER_PHASE = 200;
	localparam int          SETTLE_CYCLES    = 8;
	localparam int          PRINT_CAP        = 100;
	localparam int unsigned RUN_LIMIT_NS     = 10_000_000;

	localparam logic signed [COORD_W-1:0]    COORD_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [COORD_W-1:0]    COORD_MIN = 32'sh8000_0000;
	localparam logic signed [ANGLE_BITS-1:0] ANGLE_MAX = 16'sh7FFF;
	localparam logic signed [ANGLE_BITS-1:0] ANGLE_MIN = 16'sh8000;
	localparam logic signed [ANGLE_BITS-1:0] QUARTER   = 1 << (ANGLE_BITS - 2);

	// Op codes outside the defined set, and the register index with no register behind it.
	localparam logic [OP_W-1:0]        OP_RESERVED_LO  = 3'd5;
	localparam logic [OP_W-1:0]        OP_RESERVED_MID = 3'd6;
	localparam logic [OP_W-1:0]        OP_RESERVED_HI  = 3'd7;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE       = 2'd3;

	// Fixed-point constants of the sine/cosine series.
	localparam int                HORNER_TERMS = 6;
	localparam longint unsigned   UNIT_Q30     = 64'd1 << 30;
	localparam longint unsigned   HALF_PI_FX   = 64'd1686629713;
	localparam int                TRIG_SHIFT   = 30 - TRIG_FRAC_BITS;
	localparam longint unsigned   TRIG_HALF    = 64'd1 << (TRIG_SHIFT - 1);
	localparam longint unsigned   SIN_STEP_DIV [HORNER_TERMS] = '{156, 110, 72, 42, 20, 6};
	localparam longint unsigned   COS_STEP_DIV [HORNER_TERMS] = '{182, 132, 90, 56, 30, 12};

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	typedef struct packed {
		logic [OP_W-1:0]              op;
		logic signed [COORD_W-1:0]    x;
		logic signed [COORD_W-1:0]    y;
		logic signed [ANGLE_BITS-1:0] angle;
	} frame_request_t;

	typedef struct packed {
		logic signed [COORD_W-1:0]    x;
		logic signed [COORD_W-1:0]    y;
		logic signed [ANGLE_BITS-1:0] angle;
		logic                         sat;
	} frame_result_t;

	typedef struct {
		frame_request_t req;
		bit             fixed;
		frame_result_t  want;
	} directed_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	pftu_in_if  #(.ANGLE_BITS(ANGLE_BITS)) req_if ();
	pftu_out_if #(.ANGLE_BITS(ANGLE_BITS)) rsp_if ();

	// Shadow copy of the base pose registers.
	logic signed [COORD_W-1:0]    cur_base_x;
	logic signed [COORD_W-1:0]    cur_base_y;
	logic signed [ANGLE_BITS-1:0] cur_base_angle;

	frame_result_t pending_poses [$];
	frame_result_t hand_result;
	bit            hand_result_on;
	int unsigned   send_idle_pct;
	int unsigned   stall_pct;
	int unsigned   mismatch_count;

	// Rows with a hand-written result hold only at the reset base pose, where the
	// rotation reduces to out = (-y, x) for global-to-local and (y, -x) back.
	directed_row_t directed_rows [DIRECTED_ROWS] = '{
		'{'{OP_PT_G2L, 32'sh0001_0000, 32'sh0002_0000, 16'sh0000}, 1'b1,
			'{32'shFFFE_0000, 32'sh0001_0000, 16'sh0000, 1'b0}},
		'{'{OP_PT_G2L, COORD_MIN, COORD_MIN, 16'sh0000}, 1'b1,
			'{COORD_MAX, COORD_MIN, 16'sh0000, 1'b1}},
		'{'{OP_PT_G2L, COORD_MAX, COORD_MAX, 16'shFFFF}, 1'b1,
			'{32'sh8000_0001, COORD_MAX, 16'sh0000, 1'b0}},
		'{'{OP_PT_G2L, 32'shFFFF_FFFF, 32'shFFFF_FFFF, ANGLE_MAX}, 1'b1,
			'{32'sh0000_0001, 32'shFFFF_FFFF, 16'sh0000, 1'b0}},
		'{'{OP_PT_L2G, COORD_MIN, COORD_MAX, ANGLE_MAX}, 1'b1,
			'{COORD_MAX, COORD_MAX, 16'sh0000, 1'b1}},
		'{'{OP_PT_L2G, COORD_MAX, COORD_MIN, ANGLE_MIN}, 1'b1,
			'{COORD_MIN, 32'sh8000_0001, 16'sh0000, 1'b0}},
		'{'{OP_PT_L2G, 32'sh0001_2345, 32'shFFFF_FFFD, 16'sh0000}, 1'b1,
			'{32'shFFFF_FFFD, 32'shFFFE_DCBB, 16'sh0000, 1'b0}},
		'{'{OP_PT_L2G, 32'shFFFF_FFFF, 32'sh0000_0001, 16'sh0000}, 1'b1,
			'{32'sh0000_0001, 32'sh0000_0001, 16'sh0000, 1'b0}},
		'{'{OP_POSE_G2L, 32'sh0000_0005, 32'shFFFF_FFF9, ANGLE_MAX}, 1'b1,
			'{32'sh0000_0007, 32'sh0000_0005, 16'shBFFF, 1'b0}},
		'{'{OP_POSE_G2L, COORD_MIN, COORD_MIN, ANGLE_MIN}, 1'b1,
			'{COORD_MAX, COORD_MIN, 16'shC000, 1'b1}},
		'{'{OP_POSE_G2L, 32'sh0000_0000, 32'sh0000_0000, 16'shC000}, 1'b1,
			'{32'sh0000_0000, 32'sh0000_0000, 16'sh0000, 1'b0}},
		'{'{OP_HD_G2L, COORD_MAX, COORD_MIN, ANGLE_MIN}, 1'b1,
			'{32'sh0000_0000, 32'sh0000_0000, 16'shC000, 1'b0}},
		'{'{OP_HD_G2L, 32'sh0000_0000, 32'sh0000_0000, 16'sh3FFF}, 1'b1,
			'{32'sh0000_0000, 32'sh0000_0000, 16'sh7FFF, 1'b0}},
		'{'{OP_HD_G2L, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 16'sh4000}, 1'b1,
			'{32'sh0000_0000, 32'sh0000_0000, 16'sh8000, 1'b0}},
		'{'{OP_HD_L2G, COORD_MIN, COORD_MAX, ANGLE_MIN}, 1'b1,
			'{32'sh0000_0000, 32'sh0000_0000, 16'sh4000, 1'b0}},
		'{'{OP_HD_L2G, 32'sh0000_0000, 32'sh0000_0000, 16'sh4000}, 1'b1,
			'{32'sh0000_0000, 32'sh0000_0000, 16'sh0000, 1'b0}},
		'{'{OP_HD_L2G, 32'sh0000_0000, 32'sh0000_0000, ANGLE_MAX}, 1'b1,
			'{32'sh0000_0000, 32'sh0000_0000, 16'sh3FFF, 1'b0}},
		'{'{OP_HD_L2G, 32'sh0000_0000, 32'sh0000_0000, 16'shBFFF}, 1'b1,
			'{32'sh0000_0000, 32'sh0000_0000, 16'sh7FFF, 1'b0}},
		'{'{OP_RESERVED_LO, COORD_MAX, COORD_MAX, ANGLE_MAX}, 1'b1,
			'{32'sh0000_0000, 32'sh0000_0000, 16'sh0000, 1'b0}},
		'{'{OP_RESERVED_MID, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 16'shFFFF}, 1'b1,
			'{32'sh0000_0000, 32'sh0000_0000, 16'sh0000, 1'b0}},
		'{'{OP_RESERVED_HI, COORD_MIN, COORD_MIN, ANGLE_MIN}, 1'b1,
			'{32'sh0000_0000, 32'sh0000_0000, 16'sh0000, 1'b0}},
		'{'{OP_PT_L2G, 32'sh5555_5555, 32'shAAAA_AAAA, 16'sh5555}, 1'b0, '0},
		'{'{OP_PT_G2L, 32'shAAAA_AAAA, 32'sh5555_5555, 16'shAAAA}, 1'b0, '0},
		'{'{OP_POSE_G2L, 32'sh1234_5678, 32'shEDCB_A988, 16'sh1357}, 1'b0, '0}
	};

	pose_frame_transform_unit #(
		.ANGLE_BITS    (ANGLE_BITS),
		.TRIG_FRAC_BITS(TRIG_FRAC_BITS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.req      (req_if),
		.rsp      (rsp_if)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Rounds a rotated sum half up by the trig fraction bits.
	function automatic longint round_rot(input longint v);
		return (v + (longint'(1) <<< (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS;
	endfunction

	function automatic logic signed [COORD_W-1:0] clamp_coord(input longint v);
		if (v > longint'(COORD_MAX))
			return COORD_MAX;
		if (v < longint'(COORD_MIN))
			return COORD_MIN;
		return v[COORD_W-1:0];
	endfunction

	// Expected result beat of one request under the current base pose.
	function automatic frame_result_t frame_transform(input frame_request_t b);
		frame_result_t   r;
		longint unsigned resid, x1, x2, t, half_sq, sin_q30, cos_q30;
		longint          sr, cr, s, c, ix, iy, bx, by, dx, dy, rx, ry;
		logic [1:0]      quad;
		int              i;
		r = '0;
		ix = $signed(b.x);
		iy = $signed(b.y);
		bx = $signed(cur_base_x);
		by = $signed(cur_base_y);
		case (b.op)
			OP_PT_G2L, OP_PT_L2G, OP_POSE_G2L: begin
				// Sine and cosine of the base heading: quadrant plus a series on the residual.
				quad = cur_base_angle[ANGLE_BITS-1 -: 2];
				resid = cur_base_angle[ANGLE_BITS-3:0];
				x1 = (resid * HALF_PI_FX) >> (ANGLE_BITS - 2);
				x2 = (x1 * x1) >> 30;
				t = UNIT_Q30;
				for (i = 0; i < HORNER_TERMS; i++)
					t = UNIT_Q30 - ((x2 * t) >> 30) / SIN_STEP_DIV[i];
				sin_q30 = (x1 * t) >> 30;
				t = UNIT_Q30;
				for (i = 0; i < HORNER_TERMS; i++)
					t = UNIT_Q30 - ((x2 * t) >> 30) / COS_STEP_DIV[i];
				half_sq = ((x2 * t) >> 30) / 2;
				cos_q30 = (half_sq > UNIT_Q30) ? 64'd0 : UNIT_Q30 - half_sq;
				sr = longint'((sin_q30 + TRIG_HALF) >> TRIG_SHIFT);
				cr = longint'((cos_q30 + TRIG_HALF) >> TRIG_SHIFT);
				case (quad)
					2'd0: begin s = sr;  c = cr;  end
					2'd1: begin s = cr;  c = -sr; end
					2'd2: begin s = -sr; c = -cr; end
					default: begin s = -cr; c = sr; end
				endcase
				if (b.op == OP_PT_L2G) begin
					rx = bx + round_rot(s * ix + c * iy);
					ry = by + round_rot(s * iy - c * ix);
				end else begin
					dx = ix - bx;
					dy = iy - by;
					rx = round_rot(s * dx - c * dy);
					ry = round_rot(c * dx + s * dy);
					if (b.op == OP_POSE_G2L)
						r.angle = QUARTER + b.angle - cur_base_angle;
				end
				r.x = clamp_coord(rx);
				r.y = clamp_coord(ry);
				r.sat = (rx > longint'(COORD_MAX)) || (rx < longint'(COORD_MIN)) ||
					(ry > longint'(COORD_MAX)) || (ry < longint'(COORD_MIN));
			end
			OP_HD_G2L: r.angle = QUARTER + b.angle - cur_base_angle;
			OP_HD_L2G: r.angle = b.angle + cur_base_angle - QUARTER;
			default: ;
		endcase
		return r;
	endfunction

	function automatic logic signed [COORD_W-1:0] random_coord();
		logic signed [COORD_W-1:0] raw;
		raw = $urandom();
		case ($urandom_range(9))
			0: return COORD_MAX;
			1: return COORD_MIN;
			2, 3, 4: return raw >>> $urandom_range(28, 8);
			default: return raw;
		endcase
	endfunction

	function automatic frame_request_t random_request();
		frame_request_t b;
		if ($urandom_range(99) < 8)
			b.op = $urandom_range(OP_RESERVED_HI, OP_RESERVED_LO);
		else
			b.op = $urandom_range(OP_HD_L2G, OP_PT_G2L);
		b.x = random_coord();
		b.y = random_coord();
		b.angle = ANGLE_BITS'($urandom());
		return b;
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP)
			$display("%0t ns: mismatch: %s", $time, what);
	endtask

	task automatic set_idling(input idle_mode_t mode);
		case (mode)
			IDLE_NONE:     begin send_idle_pct = 0;  stall_pct = 0;  end
			IDLE_SENDER:   begin send_idle_pct = 85; stall_pct = 0;  end
			IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 85; end
			default:       begin send_idle_pct = 35; stall_pct = 35; end
		endcase
	endtask

	// Offers one request beat, starting at a falling edge, and returns at the falling
	// edge after it was taken. Valid stays high so the next beat can follow back to back.
	task automatic send_request(input frame_request_t b, input bit use_hand,
		input frame_result_t hand);
		while ($urandom_range(99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			@(negedge clk);
		end
		req_if.valid    <= 1'b1;
		req_if.op       <= b.op;
		req_if.in_x     <= b.x;
		req_if.in_y     <= b.y;
		req_if.in_angle <= b.angle;
		hand_result_on  <= use_hand;
		hand_result     <= hand;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic run_directed(input bit use_hand);
		int i;
		for (i = 0; i < DIRECTED_ROWS; i++)
			send_request(directed_rows[i].req, use_hand && directed_rows[i].fixed,
				directed_rows[i].want);
	endtask

	// Drops valid and waits until every expected beat has come back.
	task automatic drain_results();
		req_if.valid <= 1'b0;
		while (pending_poses.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// One register write; cfg_we is left high so writes can run back to back.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		case (idx)
			REG_BASE_X:     cur_base_x = data;
			REG_BASE_Y:     cur_base_y = data;
			REG_BASE_ANGLE: cur_base_angle = data[ANGLE_BITS-1:0];
			default: ;
		endcase
	endtask

	// Receiver side: ready is redrawn every cycle.
	always @(negedge clk)
		rsp_if.ready <= ($urandom_range(99) >= stall_pct);

	// Queue an expectation for each accepted request and check each accepted result.
	always @(posedge clk) begin : scoreboard
		frame_request_t seen;
		frame_result_t  want;
		if (arst_n) begin
			if (req_if.valid && req_if.ready) begin
				seen = '{req_if.op, req_if.in_x, req_if.in_y, req_if.in_angle};
				pending_poses.push_back(hand_result_on ? hand_result : frame_transform(seen));
			end
			if (rsp_if.valid && rsp_if.ready) begin
				if (pending_poses.size() == 0) begin
					report_mismatch("result beat with no request pending");
				end else begin
					want = pending_poses.pop_front();
					if (rsp_if.out_x !== want.x)
						report_mismatch($sformatf("out_x %h, expected %h", rsp_if.out_x, want.x));
					if (rsp_if.out_y !== want.y)
						report_mismatch($sformatf("out_y %h, expected %h", rsp_if.out_y, want.y));
					if (rsp_if.out_angle !== want.angle)
						report_mismatch($sformatf("out_angle %h, expected %h",
							rsp_if.out_angle, want.angle));
					if (rsp_if.saturated !== want.sat)
						report_mismatch($sformatf("saturated %b, expected %b",
							rsp_if.saturated, want.sat));
				end
			end
		end
	end

	// Main sequence: reset, directed table at the reset pose, then one random phase
	// per base pose, the idling pattern stepping through the four modes in turn.
	initial begin : stimulus
		logic signed [COORD_W-1:0]    bx, by;
		logic signed [ANGLE_BITS-1:0] ba;
		int                           phase;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = '0;
		cfg_data        = '0;
		req_if.valid    = 1'b0;
		req_if.op       = '0;
		req_if.in_x     = '0;
		req_if.in_y     = '0;
		req_if.in_angle = '0;
		rsp_if.ready    = 1'b0;
		hand_result_on  = 1'b0;
		hand_result     = '0;
		mismatch_count  = 0;
		cur_base_x      = '0;
		cur_base_y      = '0;
		cur_base_angle  = '0;
		set_idling(IDLE_NONE);
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		run_directed(1'b1);

		for (phase = 1; phase <= RANDOM_PHASES; phase++) begin
			drain_results();
			// Pick the base pose: the two corners first, then quadrant edges, a random heading and an eighth turn.
			bx = $urandom();
			by = $urandom();
			if (phase % 2 == 1) begin
				bx = bx >>> 12;
				by = by >>> 12;
			end
			case (phase)
				1: begin bx = COORD_MAX; by = COORD_MIN; ba = ANGLE_MIN; end
				2: begin bx = COORD_MIN; by = COORD_MAX; ba = ANGLE_MAX; end
				3: ba = QUARTER;
				4: ba = -QUARTER;
				5: ba = 16'sh0001;
				6: ba = 16'shFFFF;
				7: ba = ANGLE_BITS'($urandom());
				default: ba = QUARTER >>> 1;
			endcase
			write_reg(REG_BASE_ANGLE, {16'($urandom()), ba});
			write_reg(REG_BASE_X, bx);
			write_reg(REG_BASE_Y, by);
			if (phase == 1)
				write_reg(REG_SPARE, $urandom());
			cfg_we <= 1'b0;
			set_idling(idle_mode_t'(phase % 4));
			if (phase == 1)
				run_directed(1'b0);
			repeat (RANDOM_PER_PHASE)
				send_request(random_request(), 1'b0, '0);
		end

		drain_results();
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Backstop against a hung handshake.
	initial begin : watchdog
		#(RUN_LIMIT_NS);
		$display("== FAIL ==");
		$finish;
	end

endmodule
